FILE: rtl/core/clpu_pkg.sv
// ----------------------------------------------------------------------------
// clpu_pkg
// Shared types and constants for the command line path unquoter.
// ----------------------------------------------------------------------------
`default_nettype none

package clpu_pkg;

  // Backslash run saturation and the width of the held count
  localparam int unsigned MAX_RUN = 31;
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 2;

  // Characters with a meaning of their own
  localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005c;
  localparam logic [UNIT_W-1:0] CH_QUOTE  = 16'h0022;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PATH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARGS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Parse phases
  localparam logic [1:0] PH_PATH  = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_ARGS  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PATH_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ARGS_LIMIT = 2'd1;

  localparam logic [LIMIT_W-1:0] PATH_LIMIT_RST = 16'd260;
  localparam logic [LIMIT_W-1:0] ARGS_LIMIT_RST = 16'd1024;

  // Work handed from the front to the back: a backslash burst, then
  // optionally one character of the given kind.
  typedef struct packed {
    logic [RUN_W-1:0]  bs_count;
    logic              has_char;
    logic [UNIT_W-1:0] char_unit;
    logic [KIND_W-1:0] kind;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/clpu_front.sv
// ----------------------------------------------------------------------------
// clpu_front
// Classifies each input code unit, tracks quoting, held backslashes and
// parse phase, and turns the unit into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clpu_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [clpu_pkg::UNIT_W-1:0]  in_code_unit,
  input  wire logic                         in_end_of_line,
  input  wire logic                         q_full,
  output logic                              q_push,
  output clpu_pkg::cmd_t                    q_cmd
);

  logic [1:0]                   phase_r, phase_nxt;
  logic                         in_quotes_r, in_quotes_nxt;
  logic [clpu_pkg::RUN_W-1:0]   pend_r, pend_nxt;
  logic                         accept;
  logic                         blank;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign blank    = (in_code_unit == clpu_pkg::CH_TAB) ||
                    (in_code_unit == clpu_pkg::CH_SPACE);

  // Classification of the current unit
  always_comb begin
    phase_nxt       = phase_r;
    in_quotes_nxt   = in_quotes_r;
    pend_nxt        = pend_r;
    q_cmd.bs_count  = '0;
    q_cmd.has_char  = 1'b0;
    q_cmd.char_unit = in_code_unit;
    q_cmd.kind      = clpu_pkg::KIND_PATH;
    if (in_end_of_line) begin
      q_cmd.bs_count  = (phase_r == clpu_pkg::PH_PATH) ? pend_r : '0;
      q_cmd.has_char  = 1'b1;
      q_cmd.char_unit = '0;
      q_cmd.kind      = clpu_pkg::KIND_END;
      phase_nxt       = clpu_pkg::PH_PATH;
      in_quotes_nxt   = 1'b0;
      pend_nxt        = '0;
    end else begin
      case (phase_r)
        clpu_pkg::PH_PATH: begin
          if (blank && !in_quotes_r) begin
            q_cmd.bs_count = pend_r;
            pend_nxt       = '0;
            phase_nxt      = clpu_pkg::PH_SKIP;
          end else if (in_code_unit == clpu_pkg::CH_BSLASH) begin
            if (pend_r >= clpu_pkg::RUN_W'(clpu_pkg::MAX_RUN)) begin
              pend_nxt = clpu_pkg::RUN_W'(clpu_pkg::MAX_RUN - 1);
            end else begin
              pend_nxt = pend_r + 1'b1;
            end
          end else if (in_code_unit == clpu_pkg::CH_QUOTE) begin
            // half the run is literal; an odd run escapes the quote
            q_cmd.bs_count = pend_r >> 1;
            if (pend_r[0]) begin
              q_cmd.has_char = 1'b1;
            end else begin
              in_quotes_nxt = !in_quotes_r;
            end
            pend_nxt = '0;
          end else begin
            q_cmd.bs_count = pend_r;
            q_cmd.has_char = 1'b1;
            pend_nxt       = '0;
          end
        end
        clpu_pkg::PH_SKIP: begin
          if (!blank) begin
            q_cmd.has_char = 1'b1;
            q_cmd.kind     = clpu_pkg::KIND_ARGS;
            phase_nxt      = clpu_pkg::PH_ARGS;
          end
        end
        default: begin
          q_cmd.has_char = 1'b1;
          q_cmd.kind     = clpu_pkg::KIND_ARGS;
        end
      endcase
    end
  end

  // Only commands that produce something go to the queue
  assign q_push = accept && (q_cmd.has_char || (q_cmd.bs_count != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= clpu_pkg::PH_PATH;
      in_quotes_r <= 1'b0;
      pend_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      in_quotes_r <= in_quotes_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clpu_queue.sv
// ----------------------------------------------------------------------------
// clpu_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clpu_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire clpu_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output clpu_pkg::cmd_t      pop_cmd
);

  clpu_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clpu_back.sv
// ----------------------------------------------------------------------------
// clpu_back
// Runs commands one result a cycle unless the output stalls: the backslash
// burst, then the character, with path and argument truncation and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module clpu_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [clpu_pkg::LIMIT_W-1:0]  path_limit,
  input  wire logic [clpu_pkg::LIMIT_W-1:0]  args_limit,
  input  wire logic                          q_valid,
  input  wire clpu_pkg::cmd_t                q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [clpu_pkg::UNIT_W-1:0]        out_out_unit,
  output logic [clpu_pkg::KIND_W-1:0]        out_kind,
  output logic                               out_last
);

  // current command
  logic                           busy_r, busy_nxt;
  clpu_pkg::cmd_t                 cmd_r, cmd_nxt;
  // emitted counts for this line
  logic [clpu_pkg::LIMIT_W-1:0]   path_cnt_r, path_cnt_nxt;
  logic [clpu_pkg::LIMIT_W-1:0]   args_cnt_r, args_cnt_nxt;
  // output register
  logic                           ov_r, ov_nxt;
  logic [clpu_pkg::UNIT_W-1:0]    ou_r, ou_nxt;
  logic [clpu_pkg::KIND_W-1:0]    ok_r, ok_nxt;
  logic                           ol_r, ol_nxt;

  logic [clpu_pkg::LIMIT_W-1:0]   path_cap, args_cap;
  logic [clpu_pkg::LIMIT_W-1:0]   path_cnt_inc;
  logic                           path_room, path_room2, args_room;
  logic                           adv;
  logic                           char_ok, char_ok_after;
  logic [clpu_pkg::RUN_W-1:0]     bs_dec;

  assign path_cap     = (path_limit == '0) ? '0 : path_limit - 1'b1;
  assign args_cap     = (args_limit == '0) ? '0 : args_limit - 1'b1;
  assign path_cnt_inc = path_cnt_r + 1'b1;
  assign path_room    = path_cnt_r < path_cap;
  assign path_room2   = path_room && (path_cnt_inc != path_cap);
  assign args_room    = args_cnt_r < args_cap;
  assign adv          = !ov_r || out_ready;
  assign bs_dec       = cmd_r.bs_count - 1'b1;

  // Whether the pending character survives truncation, now or after one
  // more path backslash
  always_comb begin
    case (cmd_r.kind)
      clpu_pkg::KIND_PATH: begin
        char_ok       = cmd_r.has_char && path_room;
        char_ok_after = cmd_r.has_char && path_room2;
      end
      clpu_pkg::KIND_ARGS: begin
        char_ok       = cmd_r.has_char && args_room;
        char_ok_after = char_ok;
      end
      default: begin
        char_ok       = cmd_r.has_char;
        char_ok_after = cmd_r.has_char;
      end
    endcase
  end

  // Command sequencing and result generation
  always_comb begin
    busy_nxt     = busy_r;
    cmd_nxt      = cmd_r;
    path_cnt_nxt = path_cnt_r;
    args_cnt_nxt = args_cnt_r;
    ov_nxt       = adv ? 1'b0 : ov_r;
    ou_nxt       = ou_r;
    ok_nxt       = ok_r;
    ol_nxt       = ol_r;
    q_pop        = 1'b0;
    if (!busy_r) begin
      if (q_valid) begin
        q_pop    = 1'b1;
        cmd_nxt  = q_cmd;
        busy_nxt = 1'b1;
      end
    end else if (adv) begin
      if ((cmd_r.bs_count != '0) && path_room) begin
        // one backslash of the burst
        ov_nxt         = 1'b1;
        ou_nxt         = clpu_pkg::CH_BSLASH;
        ok_nxt         = clpu_pkg::KIND_PATH;
        path_cnt_nxt   = path_cnt_inc;
        cmd_nxt.bs_count = bs_dec;
        ol_nxt         = ((bs_dec == '0) || !path_room2) && !char_ok_after;
        if (ol_nxt) begin
          busy_nxt = 1'b0;
        end
      end else begin
        // burst done or truncated: the character, if it survives
        cmd_nxt.bs_count = '0;
        busy_nxt         = 1'b0;
        if (char_ok) begin
          ov_nxt = 1'b1;
          ou_nxt = cmd_r.char_unit;
          ok_nxt = cmd_r.kind;
          ol_nxt = 1'b1;
          case (cmd_r.kind)
            clpu_pkg::KIND_PATH: path_cnt_nxt = path_cnt_inc;
            clpu_pkg::KIND_ARGS: args_cnt_nxt = args_cnt_r + 1'b1;
            default: begin
              path_cnt_nxt = '0;
              args_cnt_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      path_cnt_r <= '0;
      args_cnt_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      path_cnt_r <= path_cnt_nxt;
      args_cnt_r <= args_cnt_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ou_r  <= ou_nxt;
    ok_r  <= ok_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid    = ov_r;
  assign out_out_unit = ou_r;
  assign out_kind     = ok_r;
  assign out_last     = ol_r;

endmodule

`default_nettype wire

FILE: rtl/core/command_line_path_unquoter_unit.sv
// A result passes through the command queue, the back end's command register and its output register.
// Throughput: the back end emits one result per cycle unless out_ready holds it off,
//   and loads each command before working on it, taking none until the last is done.
// The front takes one input per cycle while the two-entry command queue has room.
// Reset (synchronous, rst_n low) clears parse state, counts and the queue and sets
//   path_limit to 260 and args_limit to 1024.
// ----------------------------------------------------------------------------
// command_line_path_unquoter_unit
// Splits a UTF-16 command line into the unquoted program path and the
// argument text, with per-part truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_path_unquoter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [clpu_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [clpu_pkg::LIMIT_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [clpu_pkg::UNIT_W-1:0]   in_code_unit,
  input  wire logic                          in_end_of_line,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [clpu_pkg::UNIT_W-1:0]        out_out_unit,
  output logic [clpu_pkg::KIND_W-1:0]        out_kind,
  output logic                               out_last
);

  logic [clpu_pkg::LIMIT_W-1:0] path_limit_r;
  logic [clpu_pkg::LIMIT_W-1:0] args_limit_r;
  logic                         q_full, q_push, q_pop, q_valid;
  clpu_pkg::cmd_t               push_cmd, pop_cmd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_limit_r <= clpu_pkg::PATH_LIMIT_RST;
      args_limit_r <= clpu_pkg::ARGS_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == clpu_pkg::REG_PATH_LIMIT) begin
        path_limit_r <= cfg_data;
      end else if (cfg_index == clpu_pkg::REG_ARGS_LIMIT) begin
        args_limit_r <= cfg_data;
      end
    end
  end

  clpu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_end_of_line (in_end_of_line),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  clpu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  clpu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .path_limit   (path_limit_r),
    .args_limit   (args_limit_r),
    .q_valid      (q_valid),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_unit (out_out_unit),
    .out_kind     (out_kind),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

FILE: bench/tb_command_line_path_unquoter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_line_path_unquoter_unit
// Self-checking bench for the command line path unquoter. A queue of command
// line units feeds a clocked driver, and a clocked monitor checks each result
// against a local model of the unquoting rules. Both sides idle at random,
// and once the receiver holds off long enough for the input to stall. The
// path and argument limits are moved through several settings between lines.
// ----------------------------------------------------------------------------

module tb_command_line_path_unquoter_unit;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_PER_ITEM   = 32;

  localparam logic [clpu_pkg::RUN_W-1:0] RUN_TOP  = clpu_pkg::RUN_W'(clpu_pkg::MAX_RUN);
  localparam logic [clpu_pkg::RUN_W-1:0] RUN_BACK = clpu_pkg::RUN_W'(clpu_pkg::MAX_RUN - 1);

  typedef struct {
    logic [clpu_pkg::UNIT_W-1:0] unit;
    logic                        eol;
  } line_unit_t;

  typedef struct {
    logic [clpu_pkg::UNIT_W-1:0] unit;
    logic [clpu_pkg::KIND_W-1:0] kind;
    logic                        last;
  } emitted_t;

  // DUT ports
  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [clpu_pkg::CIDX_W-1:0]   cfg_index      = clpu_pkg::REG_PATH_LIMIT;
  logic [clpu_pkg::LIMIT_W-1:0]  cfg_data       = '0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [clpu_pkg::UNIT_W-1:0]   in_code_unit   = '0;
  logic                          in_end_of_line = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [clpu_pkg::UNIT_W-1:0]   out_out_unit;
  logic [clpu_pkg::KIND_W-1:0]   out_kind;
  logic                          out_last;

  command_line_path_unquoter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_unit   (out_out_unit),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

  always #2 clk = ~clk;

  // Shared bench state
  line_unit_t  units_to_send[$];
  emitted_t    awaited_chars[$];
  emitted_t    step_chars[$];
  int unsigned queued_units   = 0;
  int unsigned mismatch_count = 0;
  bit          stress_armed   = 1'b0;

  // Local copy of the parser state and the limits
  logic [clpu_pkg::LIMIT_W-1:0] path_lim = clpu_pkg::PATH_LIMIT_RST;
  logic [clpu_pkg::LIMIT_W-1:0] args_lim = clpu_pkg::ARGS_LIMIT_RST;
  logic                         quoted   = 1'b0;
  logic [clpu_pkg::RUN_W-1:0]   held_bs  = '0;
  logic [1:0]                   parse_ph = clpu_pkg::PH_PATH;
  logic [clpu_pkg::LIMIT_W-1:0] path_cnt = '0;
  logic [clpu_pkg::LIMIT_W-1:0] args_cnt = '0;

  // ---------------------------------------------------------------------------
  // Unquoting model
  // ---------------------------------------------------------------------------
  function automatic logic [clpu_pkg::LIMIT_W-1:0] keep_max(
      input logic [clpu_pkg::LIMIT_W-1:0] lim);
    return (lim == '0) ? '0 : lim - 1'b1;
  endfunction

  task automatic emit_char(input logic [clpu_pkg::UNIT_W-1:0] u,
                           input logic [clpu_pkg::KIND_W-1:0] k);
    emitted_t r;
    if (step_chars.size() < MAX_PER_ITEM) begin
      r.unit = u;
      r.kind = k;
      r.last = 1'b0;
      step_chars.push_back(r);
    end
  endtask

  task automatic put_path(input logic [clpu_pkg::UNIT_W-1:0] u);
    if (path_cnt < keep_max(path_lim)) begin
      emit_char(u, clpu_pkg::KIND_PATH);
      path_cnt++;
    end
  endtask

  task automatic put_args(input logic [clpu_pkg::UNIT_W-1:0] u);
    if (args_cnt < keep_max(args_lim)) begin
      emit_char(u, clpu_pkg::KIND_ARGS);
      args_cnt++;
    end
  endtask

  task automatic put_run(input logic [clpu_pkg::RUN_W-1:0] n);
    for (int i = 0; i < int'(n); i++) put_path(clpu_pkg::CH_BSLASH);
  endtask

  task automatic unquote_step(input logic [clpu_pkg::UNIT_W-1:0] c, input logic eol);
    logic blank;
    blank = (c == clpu_pkg::CH_TAB) || (c == clpu_pkg::CH_SPACE);
    step_chars.delete();
    if (eol) begin
      // held backslashes flush as literals, then the end marker
      if (parse_ph == clpu_pkg::PH_PATH) put_run(held_bs);
      emit_char('0, clpu_pkg::KIND_END);
      quoted   = 1'b0;
      held_bs  = '0;
      parse_ph = clpu_pkg::PH_PATH;
      path_cnt = '0;
      args_cnt = '0;
    end else if (parse_ph == clpu_pkg::PH_PATH) begin
      if (blank && !quoted) begin
        put_run(held_bs);
        held_bs  = '0;
        parse_ph = clpu_pkg::PH_SKIP;
      end else if (c == clpu_pkg::CH_BSLASH) begin
        // saturate but keep parity
        if (held_bs >= RUN_TOP) held_bs = RUN_BACK;
        else held_bs = held_bs + 1'b1;
      end else if (c == clpu_pkg::CH_QUOTE) begin
        put_run(held_bs >> 1);
        if (held_bs[0]) put_path(clpu_pkg::CH_QUOTE);
        else quoted = !quoted;
        held_bs = '0;
      end else begin
        put_run(held_bs);
        held_bs = '0;
        put_path(c);
      end
    end else if (parse_ph == clpu_pkg::PH_SKIP) begin
      if (!blank) begin
        parse_ph = clpu_pkg::PH_ARGS;
        put_args(c);
      end
    end else begin
      put_args(c);
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    foreach (step_chars[i]) awaited_chars.push_back(step_chars[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction per queued unit, random gaps
  // ---------------------------------------------------------------------------
  int unsigned send_gap    = 0;
  bit          send_steady = 1'b0;
  line_unit_t  next_unit;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        unquote_step(in_code_unit, in_end_of_line);
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (units_to_send.size() > 0) begin
          next_unit = units_to_send.pop_front();
          in_valid       <= 1'b1;
          in_code_unit   <= next_unit.unit;
          in_end_of_line <= next_unit.eol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result, random stalls, one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned recv_stall  = 0;
  int unsigned hold_left   = 0;
  bit          recv_steady = 1'b0;
  bit          stress_done = 1'b0;
  emitted_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_chars.size() == 0) begin
          flag_mismatch("result with nothing expected, unit", 32'(out_out_unit), 32'd0);
        end else begin
          want = awaited_chars.pop_front();
          if (out_out_unit !== want.unit)
            flag_mismatch("out_unit", 32'(out_out_unit), 32'(want.unit));
          if (out_kind !== want.kind) flag_mismatch("kind", 32'(out_kind), 32'(want.kind));
          if (out_last !== want.last) flag_mismatch("last", 32'(out_last), 32'(want.last));
        end
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        recv_stall = recv_steady ? 0 : $urandom_range(0, 3);
        if (stress_armed && !stress_done) begin
          hold_left   = HOLD_CYCLES;
          stress_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog on cycles without any transaction
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [clpu_pkg::UNIT_W-1:0] u, input logic eol);
    line_unit_t it;
    it.unit = u;
    it.eol  = eol;
    units_to_send.push_back(it);
    queued_units++;
  endtask

  function automatic logic [clpu_pkg::UNIT_W-1:0] pick_blank();
    return ($urandom_range(0, 1) == 0) ? clpu_pkg::CH_SPACE : clpu_pkg::CH_TAB;
  endfunction

  function automatic logic [clpu_pkg::UNIT_W-1:0] pick_letter();
    return clpu_pkg::UNIT_W'(16'h0061 + $urandom_range(0, 25));
  endfunction

  // one command line: mostly well formed, some noise, some without an end
  task automatic queue_line();
    int unsigned sel;
    int unsigned n;
    int unsigned run;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      n = $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++)
        push_item(clpu_pkg::UNIT_W'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      // path
      n = $urandom_range(0, 8);
      for (int unsigned i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 40) : $urandom_range(1, 4);
            repeat (run) push_item(clpu_pkg::CH_BSLASH, 1'b0);
          end
          3, 4: push_item(clpu_pkg::CH_QUOTE, 1'b0);
          5: push_item(pick_blank(), 1'b0);
          6: push_item(clpu_pkg::UNIT_W'($urandom), 1'b0);
          default: push_item(pick_letter(), 1'b0);
        endcase
      end
      // separator
      n = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) push_item(pick_blank(), 1'b0);
      // arguments
      n = $urandom_range(0, 8);
      for (int unsigned i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0: push_item(pick_blank(), 1'b0);
          1: push_item(($urandom_range(0, 1) == 0) ? clpu_pkg::CH_QUOTE : clpu_pkg::CH_BSLASH,
                       1'b0);
          2: push_item(clpu_pkg::UNIT_W'($urandom), 1'b0);
          default: push_item(pick_letter(), 1'b0);
        endcase
      end
      if (sel != 1) push_item(clpu_pkg::UNIT_W'($urandom), 1'b1);
    end
  endtask

  // lines until about n units are queued, closed by an end of line
  task automatic queue_random(input int unsigned n);
    int unsigned start;
    start = queued_units;
    while (queued_units - start < n) queue_line();
    push_item(clpu_pkg::UNIT_W'($urandom), 1'b1);
  endtask

  task automatic write_reg(input logic [clpu_pkg::CIDX_W-1:0] idx,
                           input logic [clpu_pkg::LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == clpu_pkg::REG_PATH_LIMIT) path_lim = val;
    else if (idx == clpu_pkg::REG_ARGS_LIMIT) args_lim = val;
  endtask

  task automatic set_limits(input logic [clpu_pkg::LIMIT_W-1:0] p,
                            input logic [clpu_pkg::LIMIT_W-1:0] a);
    write_reg(clpu_pkg::REG_PATH_LIMIT, p);
    write_reg(clpu_pkg::REG_ARGS_LIMIT, a);
  endtask

  // block drained: nothing queued, in flight or awaited
  task automatic wait_idle();
    while (units_to_send.size() != 0 || in_valid || awaited_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed line: quoting, even and odd backslash runs before a quote,
    // zero and all-ones units, tab ending the path, blanks skipped, verbatim args
    push_item(clpu_pkg::CH_QUOTE, 1'b0);
    push_item(16'h0043, 1'b0);
    push_item(clpu_pkg::CH_SPACE, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_QUOTE, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_QUOTE, 1'b0);
    push_item(16'h0000, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(clpu_pkg::CH_TAB, 1'b0);
    push_item(clpu_pkg::CH_SPACE, 1'b0);
    push_item(clpu_pkg::CH_TAB, 1'b0);
    push_item(16'h0078, 1'b0);
    push_item(clpu_pkg::CH_QUOTE, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_SPACE, 1'b0);
    push_item(16'hFFFF, 1'b1);
    // end of line with backslashes still held
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(clpu_pkg::CH_BSLASH, 1'b0);
    push_item(16'h0000, 1'b1);
    // end of line while skipping blanks
    push_item(16'h0061, 1'b0);
    push_item(clpu_pkg::CH_SPACE, 1'b0);
    push_item(16'h1234, 1'b1);
    wait_idle();

    // smallest buffers: nothing kept but end markers
    set_limits(16'd1, 16'd1);
    @(negedge clk);
    queue_random(20);
    wait_idle();

    // zero limit behaves as one
    set_limits(16'd0, 16'd0);
    @(negedge clk);
    queue_random(15);
    wait_idle();

    // largest buffers, with the long receiver hold-off
    set_limits(16'hFFFF, 16'hFFFF);
    @(negedge clk);
    queue_random(35);
    stress_armed = 1'b1;
    wait_idle();

    // tight truncation
    set_limits(16'd4, 16'd3);
    @(negedge clk);
    queue_random(35);
    wait_idle();

    // random small limits
    set_limits(clpu_pkg::LIMIT_W'($urandom_range(1, 12)),
               clpu_pkg::LIMIT_W'($urandom_range(1, 12)));
    @(negedge clk);
    queue_random(25);
    wait_idle();

    // back to the reset values
    set_limits(clpu_pkg::PATH_LIMIT_RST, clpu_pkg::ARGS_LIMIT_RST);
    @(negedge clk);
    queue_random(20);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
